// File: design/nmea_pkg.sv
package nmea_pkg;

    // Default sizes of the sentence buffer and of the stored body.
    localparam int RX_DEPTH_DEFAULT = 512;
    localparam int BODY_MAX_DEFAULT = 128;

    localparam int BYTE_W     = 8;
    localparam int HDR_BYTES  = 5;
    localparam int BODY_LEN_W = 7;
    localparam int TOTAL_W    = 32;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    // Body positions whose commas mark an empty sentence.
    localparam int COMMA_POS_A = 6;
    localparam int COMMA_POS_B = 7;

    typedef enum logic [2:0] {
        TYPE_UNKNOWN = 3'd0,
        TYPE_GGA     = 3'd1,
        TYPE_VTG     = 3'd2,
        TYPE_GSA     = 3'd3,
        TYPE_RMC     = 3'd4,
        TYPE_GSV     = 3'd5,
        TYPE_ZDA     = 3'd6
    } sentence_type_t;

    typedef enum logic [1:0] {
        CHECK_NONE  = 2'd0,
        CHECK_EMPTY = 2'd1,
        CHECK_GOOD  = 2'd2,
        CHECK_BAD   = 2'd3
    } check_status_t;

    typedef logic [HDR_BYTES-1:0][BYTE_W-1:0] header_t;

    localparam int NUM_TYPES = 6;

    // Known sentence names; the first character sits in the top byte.
    localparam logic [NUM_TYPES-1:0][HDR_BYTES*BYTE_W-1:0] TYPE_NAMES = '{
        "GPZDA", "GPGSV", "GPRMC", "GPGSA", "GPVTG", "GPGGA"
    };

    // Returns {is_digit, value} for one ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    // Names the sentence from its first five body bytes.
    function automatic sentence_type_t name_type(input header_t hdr, input logic long_enough);
        sentence_type_t t;
        logic           same;
        t = TYPE_UNKNOWN;
        for (int i = NUM_TYPES - 1; i >= 0; i--) begin
            same = 1'b1;
            for (int k = 0; k < HDR_BYTES; k++) begin
                if (hdr[k] != TYPE_NAMES[i][BYTE_W*(HDR_BYTES-1-k) +: BYTE_W]) begin
                    same = 1'b0;
                end
            end
            if (same && long_enough) begin
                t = sentence_type_t'(3'(i + 1));
            end
        end
        return t;
    endfunction

endpackage

// File: design/nmea_sentence_framer.sv
// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  ------------------------------------------
// in       sink       in_valid / in_ready     rx_byte
// out      source     out_valid / out_ready   sentence_type, check_status, body_length,
//                                             truncated, computed_sum, received_sum,
//                                             good_total, bad_total
//
// Every input transaction is folded into the sentence state in the cycle it is
// accepted, so the block takes one byte per clock while in_ready is high. The LF that closes a
// sentence loads the result register, and out_valid rises on the next cycle.
// in_ready drops only while a result sits in the result register and out_ready
// is low; a result that is taken in the same cycle frees the slot at once.
// Reset clears the sentence state, the counters and out_valid; the block then
// hunts for the next dollar sign.
module nmea_sentence_framer
    import nmea_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEFAULT,
    parameter int BODY_MAX = BODY_MAX_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     rx_byte,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            sentence_type,
    output logic [1:0]            check_status,
    output logic [BODY_LEN_W-1:0] body_length,
    output logic                  truncated,
    output logic [BYTE_W-1:0]     computed_sum,
    output logic [BYTE_W-1:0]     received_sum,
    output logic [TOTAL_W-1:0]    good_total,
    output logic [TOTAL_W-1:0]    bad_total
);

    // The body count reaches BODY_MAX-1 at most; the fill count reaches RX_DEPTH.
    localparam int CW = $clog2(BODY_MAX);
    localparam int FW = $clog2(RX_DEPTH + 1);

    // Everything that belongs to the sentence being collected.
    typedef struct packed {
        logic [CW-1:0]     count;
        logic              cut;
        header_t           hdr;
        logic [1:0]        commas;
        logic [BYTE_W-1:0] xsum;
        logic              star;
        logic              hex_active;
        logic [BYTE_W-1:0] hex_value;
    } body_t;

    // Adds one byte to the body: header capture, comma marks, checksum, hex digits; a full body is marked cut instead.
    function automatic body_t append(input body_t s, input logic [BYTE_W-1:0] b);
        body_t      r;
        logic [4:0] d;
        r = s;
        d = hex_digit(b);
        if (s.count >= CW'(BODY_MAX - 1)) begin
            r.cut = 1'b1;
        end
        else begin
            if (s.count < CW'(HDR_BYTES)) begin
                r.hdr[s.count[2:0]] = b;
            end
            if (s.count == CW'(COMMA_POS_A) && b == CH_COMMA) begin
                r.commas[0] = 1'b1;
            end
            if (s.count == CW'(COMMA_POS_B) && b == CH_COMMA) begin
                r.commas[1] = 1'b1;
            end
            if (!s.star) begin
                if (b == CH_STAR) begin
                    r.star       = 1'b1;
                    r.hex_active = 1'b1;
                    r.hex_value  = '0;
                end
                else begin
                    r.xsum = s.xsum ^ b;
                end
            end
            else if (s.hex_active) begin
                if (!d[4]) begin
                    r.hex_active = 1'b0;
                end
                else begin
                    r.hex_value = {s.hex_value[3:0], d[3:0]};
                end
            end
            r.count = s.count + CW'(1);
        end
        return r;
    endfunction

    logic                 in_sentence_reg, in_sentence_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic                 pending_cr_reg, pending_cr_next;
    body_t                body_reg, body_next;
    logic [TOTAL_W-1:0]   good_count_reg, good_count_next;
    logic [TOTAL_W-1:0]   bad_count_reg, bad_count_next;

    logic                 out_valid_reg, out_valid_next;
    sentence_type_t       type_reg, type_next;
    check_status_t        status_reg, status_next;
    logic [BODY_LEN_W-1:0] length_reg, length_next;
    logic                 cut_reg, cut_next;
    logic [BYTE_W-1:0]    csum_reg, csum_next;
    logic [BYTE_W-1:0]    rsum_reg, rsum_next;
    logic [TOTAL_W-1:0]   good_out_reg, good_out_next;
    logic [TOTAL_W-1:0]   bad_out_reg, bad_out_next;

    logic                 in_fire;
    logic                 result_load;
    logic [FW-1:0]        fill_inc;
    body_t                body_work;
    sentence_type_t       found_type;

    // A result waiting in the register blocks input only until it is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign fill_inc = fill_reg + FW'(1);

    assign found_type = name_type(body_reg.hdr, body_reg.count >= CW'(HDR_BYTES));

    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        fill_next        = fill_reg;
        pending_cr_next  = pending_cr_reg;
        body_next        = body_reg;
        good_count_next  = good_count_reg;
        bad_count_next   = bad_count_reg;
        result_load      = 1'b0;
        status_next      = CHECK_NONE;
        body_work        = body_reg;

        if (in_fire) begin
            if (!in_sentence_reg) begin
                if (rx_byte == CH_DOLLAR) begin
                    in_sentence_next = 1'b1;
                    fill_next        = FW'(1);
                    pending_cr_next  = 1'b0;
                    body_next        = '0;
                end
            end
            else if (pending_cr_reg && rx_byte == CH_LF) begin
                // End of sentence: classify, check and count.
                result_load = 1'b1;
                if (found_type == TYPE_UNKNOWN) begin
                    status_next = CHECK_NONE;
                end
                else if (body_reg.commas == 2'b11) begin
                    status_next = CHECK_EMPTY;
                end
                else if (body_reg.xsum == body_reg.hex_value) begin
                    status_next     = CHECK_GOOD;
                    good_count_next = good_count_reg + TOTAL_W'(1);
                end
                else begin
                    status_next    = CHECK_BAD;
                    bad_count_next = bad_count_reg + TOTAL_W'(1);
                end
                in_sentence_next = 1'b0;
                fill_next        = '0;
                pending_cr_next  = 1'b0;
                body_next        = '0;
            end
            else begin
                // A held CR that is not followed by LF is an ordinary body byte.
                if (pending_cr_reg) begin
                    body_work = append(body_work, CH_CR);
                end
                if (rx_byte != CH_CR) begin
                    body_work = append(body_work, rx_byte);
                end
                pending_cr_next = (rx_byte == CH_CR);
                body_next       = body_work;
                fill_next       = fill_inc;
                // A run that fills the buffer without ending is dropped.
                if (fill_inc >= FW'(RX_DEPTH)) begin
                    in_sentence_next = 1'b0;
                    fill_next        = '0;
                    pending_cr_next  = 1'b0;
                    body_next        = '0;
                end
            end
        end
    end

    // Result register contents.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        type_next      = type_reg;
        length_next    = length_reg;
        cut_next       = cut_reg;
        csum_next      = csum_reg;
        rsum_next      = rsum_reg;
        good_out_next  = good_out_reg;
        bad_out_next   = bad_out_reg;
        if (result_load) begin
            out_valid_next = 1'b1;
            type_next      = found_type;
            length_next    = BODY_LEN_W'(body_reg.count);
            cut_next       = body_reg.cut;
            csum_next      = body_reg.xsum;
            rsum_next      = body_reg.hex_value;
            good_out_next  = good_count_next;
            bad_out_next   = bad_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_sentence_reg <= 1'b0;
            fill_reg        <= '0;
            pending_cr_reg  <= 1'b0;
            body_reg        <= '0;
            good_count_reg  <= '0;
            bad_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            in_sentence_reg <= in_sentence_next;
            fill_reg        <= fill_next;
            pending_cr_reg  <= pending_cr_next;
            body_reg        <= body_next;
            good_count_reg  <= good_count_next;
            bad_count_reg   <= bad_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        status_reg   <= result_load ? status_next : status_reg;
        length_reg   <= length_next;
        cut_reg      <= cut_next;
        csum_reg     <= csum_next;
        rsum_reg     <= rsum_next;
        good_out_reg <= good_out_next;
        bad_out_reg  <= bad_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign sentence_type = type_reg;
    assign check_status  = status_reg;
    assign body_length   = length_reg;
    assign truncated     = cut_reg;
    assign computed_sum  = csum_reg;
    assign received_sum  = rsum_reg;
    assign good_total    = good_out_reg;
    assign bad_total     = bad_out_reg;

endmodule
